/* rtl/cbf_pkg.sv */
// Shared types, register indexes and output packing for the cubic Bezier flattener.
package cbf_pkg;

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_COORD_SCALE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FLAT_TOLERANCE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_PRECISION = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NEGATE_Y       = 3'd4;

	typedef struct packed {
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] ctrl1_x;
		logic signed [31:0] ctrl1_y;
		logic signed [31:0] ctrl2_x;
		logic signed [31:0] ctrl2_y;
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
		logic               path_start;
	} seg_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic               last_point;
	} pt_t;

	// sign and rounded magnitude to a saturated 32-bit value
	function automatic logic signed [31:0] pack32(input logic neg, input logic [64:0] r);
		logic [64:0] rr;
		rr = r;
		if (neg) begin
			if (rr > 65'h80000000) rr = 65'h80000000;
			rr = ~rr + 65'd1;
		end else begin
			if (rr > 65'h7FFFFFFF) rr = 65'h7FFFFFFF;
		end
		return rr[31:0];
	endfunction

	// integer rounding of a Q.32 magnitude, halves away from zero
	function automatic logic [64:0] rnd32(input logic [64:0] mag);
		return (mag + 65'h80000000) >> 32;
	endfunction

endpackage

/* rtl/cubic_bezier_flattener.sv */
// Cubic Bezier flattener: line test, scaling, subdivision stack and flatness sequencer.
//
//  channel   | signals                       | beat
//  ----------+-------------------------------+--------------------------------
//  segment   | seg_valid, seg_ready, seg     | one cubic segment, Q16.16
//  point     | pt_valid, pt_ready, pt        | one polyline point
//  config    | cfg_we, cfg_index, cfg_data   | one register write
//
// One segment at a time. Each subdivision node runs ST_DIFF, then ST_OPSET, ST_MUL and ST_ACC
// for each product on the shift-add unit, then ST_TEST; ST_MUL runs over the bits of the
// multiplier operand, and a node taken from the stack first passes ST_POP and ST_LOAD. Up to
// 2^L - 1 nodes per segment, L being max_depth clamped to 1..MAX_LEVELS; pending right halves
// sit in the stack memory. Reset clears control state and loads register defaults. A stalled point
// output stops the sequencer at the next point, one point is held back to mark the last one.
module cubic_bezier_flattener
	import cbf_pkg::*;
#(
	parameter int MAX_LEVELS = 6,
	parameter int COORD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 seg_valid,
	output logic                 seg_ready,
	input  seg_t                 seg,
	output logic                 pt_valid,
	input  logic                 pt_ready,
	output pt_t                  pt,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	localparam int W      = COORD_BITS + 16;
	localparam int DW     = W + 1;
	localparam int AW     = 2 * W + 3;
	localparam int PW     = 4 * W + 6;
	localparam int LW     = $clog2(MAX_LEVELS + 1);
	localparam int SD     = MAX_LEVELS;
	localparam int AIW    = (SD > 1) ? $clog2(SD) : 1;
	localparam int SPW    = $clog2(SD + 1);
	localparam int NODE_W = 8 * W + LW;

	localparam logic [2:0] OP_C2A = 3'd0;
	localparam logic [2:0] OP_C2B = 3'd1;
	localparam logic [2:0] OP_C3A = 3'd2;
	localparam logic [2:0] OP_C3B = 3'd3;
	localparam logic [2:0] OP_LHS = 3'd4;
	localparam logic [2:0] OP_DXX = 3'd5;
	localparam logic [2:0] OP_DYY = 3'd6;
	localparam logic [2:0] OP_TOL = 3'd7;

	typedef enum logic [12:0] {
		ST_IDLE  = 13'b0000000000001,
		ST_START = 13'b0000000000010,
		ST_DIR   = 13'b0000000000100,
		ST_LTEST = 13'b0000000001000,
		ST_CONV  = 13'b0000000010000,
		ST_DIFF  = 13'b0000000100000,
		ST_OPSET = 13'b0000001000000,
		ST_MUL   = 13'b0000010000000,
		ST_ACC   = 13'b0000100000000,
		ST_TEST  = 13'b0001000000000,
		ST_POP   = 13'b0010000000000,
		ST_LOAD  = 13'b0100000000000,
		ST_FLUSH = 13'b1000000000000
	} state_t;

	state_t state_q;

	logic [31:0] scale_q, tol_q;
	logic [15:0] lp_q;
	logic [2:0]  depth_q;
	logic        negy_q;

	seg_t               seg_q;
	logic signed [31:0] crd [8];
	logic [1:0]         dk_q;
	logic               dir_end_q;
	logic [3:0]         cv_q;
	logic [2:0]         msel;
	logic signed [64:0] prod_s1, px_q;
	logic signed [65:0] mul_full;

	logic signed [W-1:0] cur_q [8];
	logic signed [W-1:0] lft [8];
	logic signed [W-1:0] rgt [8];
	logic [LW-1:0]       lev_q;
	logic [SPW-1:0]      sp_q;

	logic signed [DW-1:0] dx_q, dy_q, d2x_q, d2y_q, d3x_q, d3y_q;
	logic [2:0]           op_q;
	logic [PW-1:0]        ma_q, mp_q, op_a;
	logic [AW-1:0]        mb_q, op_b;
	logic                 msg_q, op_sg;
	logic signed [AW-1:0] cr_q, sprod, cdiff;
	logic [AW-1:0]        d23_q, nsum_q;
	logic [PW-1:0]        lhs_q, n_q;

	logic [NODE_W-1:0] mem [SD];
	logic [NODE_W-1:0] rd_q, wr_data;
	logic              wr_en, rd_en;
	logic [AIW-1:0]    wr_addr, rd_addr;

	logic               line_ok, split;
	logic [LW-1:0]      lev_init;
	logic               emit_req, emit_ok, emit_fire, flush_ok, load_out;
	logic signed [31:0] emit_x, emit_y, hold_x_q, hold_y_q;
	logic               hold_v_q, out_v_q;
	pt_t                out_q;

	assign crd[0] = seg_q.start_x;
	assign crd[1] = seg_q.start_y;
	assign crd[2] = seg_q.ctrl1_x;
	assign crd[3] = seg_q.ctrl1_y;
	assign crd[4] = seg_q.ctrl2_x;
	assign crd[5] = seg_q.ctrl2_y;
	assign crd[6] = seg_q.end_x;
	assign crd[7] = seg_q.end_y;

	function automatic logic [DW-1:0] magd(input logic signed [DW-1:0] v);
		return v[DW-1] ? DW'(-v) : DW'(v);
	endfunction

	function automatic logic [AW-1:0] maga(input logic signed [AW-1:0] v);
		return v[AW-1] ? AW'(-v) : AW'(v);
	endfunction

	function automatic logic [64:0] mag65(input logic signed [64:0] v);
		return v[64] ? 65'(-v) : 65'(v);
	endfunction

	// |3c - 2a - b| < thr on unscaled inputs
	function automatic logic lt_ok(input logic signed [31:0] c, input logic signed [31:0] a,
			input logic signed [31:0] b, input logic signed [35:0] thr);
		logic signed [35:0] v;
		v = 36'(c) * 36'sd3 - 36'(a) * 36'sd2 - 36'(b);
		if (v < 0) v = -v;
		return v < thr;
	endfunction

	// scaled Q.32 product to saturated Q.16 working value
	function automatic logic signed [W-1:0] to_work(input logic signed [64:0] p);
		logic [64:0] r, half, rs;
		r    = (mag65(p) + 65'd32768) >> 16;
		half = 65'd1 << (W - 1);
		if (p[64]) begin
			if (r > half) r = half;
			rs = ~r + 65'd1;
		end else begin
			if (r > half - 65'd1) r = half - 65'd1;
			rs = r;
		end
		return rs[W-1:0];
	endfunction

	function automatic logic signed [31:0] work_pt(input logic signed [W-1:0] v,
			input logic flip);
		logic signed [64:0] ve;
		ve = 65'(v);
		return pack32(v[W-1] ^ flip, (mag65(ve) + 65'd32768) >> 16);
	endfunction

	function automatic logic signed [W-1:0] mid(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		logic signed [W:0] s;
		s = (W + 1)'(a) + (W + 1)'(b);
		return W'(s >>> 1);
	endfunction

	// scaling multiplier, one coordinate per cycle
	always_comb begin
		if (state_q == ST_CONV) msel = cv_q[2:0];
		else msel = (dir_end_q ? 3'd6 : 3'd0) + {2'd0, dk_q != 2'd0};
	end
	assign mul_full = 66'(crd[msel]) * $signed({34'd0, scale_q});

	always_comb begin
		logic signed [35:0] thr;
		thr = $signed(36'({lp_q, 1'b0}) + 36'(lp_q));
		line_ok = lt_ok(seg_q.ctrl1_x, seg_q.start_x, seg_q.end_x, thr) &&
			lt_ok(seg_q.ctrl2_x, seg_q.end_x, seg_q.start_x, thr) &&
			lt_ok(seg_q.ctrl1_y, seg_q.start_y, seg_q.end_y, thr) &&
			lt_ok(seg_q.ctrl2_y, seg_q.end_y, seg_q.start_y, thr);
	end

	always_comb begin
		if (depth_q == 3'd0) lev_init = LW'(1);
		else if (int'(depth_q) > MAX_LEVELS) lev_init = LW'(MAX_LEVELS);
		else lev_init = LW'(depth_q);
	end

	// de Casteljau halves of the current node
	always_comb begin
		logic signed [W-1:0] a12, a23, a34, a123, a234, a1234;
		for (int i = 0; i < 2; i++) begin
			a12   = mid(cur_q[i], cur_q[2+i]);
			a23   = mid(cur_q[2+i], cur_q[4+i]);
			a34   = mid(cur_q[4+i], cur_q[6+i]);
			a123  = mid(a12, a23);
			a234  = mid(a23, a34);
			a1234 = mid(a123, a234);
			lft[i]   = cur_q[i];
			lft[2+i] = a12;
			lft[4+i] = a123;
			lft[6+i] = a1234;
			rgt[i]   = a1234;
			rgt[2+i] = a234;
			rgt[4+i] = a34;
			rgt[6+i] = cur_q[6+i];
		end
	end

	always_comb begin
		wr_data = '0;
		wr_data[LW-1:0] = lev_q - LW'(1);
		for (int i = 0; i < 8; i++) wr_data[LW + i * W +: W] = rgt[i];
	end

	// operand select for the shift-add unit
	always_comb begin
		op_a  = '0;
		op_b  = '0;
		op_sg = 1'b0;
		case (op_q)
			OP_C2A: begin
				op_a = PW'(magd(d2x_q)); op_b = AW'(magd(dy_q)); op_sg = d2x_q[DW-1] ^ dy_q[DW-1];
			end
			OP_C2B: begin
				op_a = PW'(magd(d2y_q)); op_b = AW'(magd(dx_q)); op_sg = d2y_q[DW-1] ^ dx_q[DW-1];
			end
			OP_C3A: begin
				op_a = PW'(magd(d3x_q)); op_b = AW'(magd(dy_q)); op_sg = d3x_q[DW-1] ^ dy_q[DW-1];
			end
			OP_C3B: begin
				op_a = PW'(magd(d3y_q)); op_b = AW'(magd(dx_q)); op_sg = d3y_q[DW-1] ^ dx_q[DW-1];
			end
			OP_LHS: begin
				op_a = PW'(d23_q); op_b = d23_q;
			end
			OP_DXX: begin
				op_a = PW'(magd(dx_q)); op_b = AW'(magd(dx_q));
			end
			OP_DYY: begin
				op_a = PW'(magd(dy_q)); op_b = AW'(magd(dy_q));
			end
			default: begin
				op_a = PW'(nsum_q); op_b = AW'(tol_q);
			end
		endcase
	end

	assign sprod = msg_q ? -$signed(mp_q[AW-1:0]) : $signed(mp_q[AW-1:0]);
	assign cdiff = cr_q - sprod;
	assign split = lhs_q >= n_q;

	// point generation
	always_comb begin
		emit_req = 1'b0;
		emit_x   = work_pt(cur_q[6], 1'b0);
		emit_y   = work_pt(cur_q[7], negy_q);
		if (state_q == ST_DIR && dk_q == 2'd2) begin
			emit_req = 1'b1;
			emit_x   = pack32(px_q[64], rnd32(mag65(px_q)));
			emit_y   = pack32(prod_s1[64] ^ negy_q, rnd32(mag65(prod_s1)));
		end else if (state_q == ST_TEST && !split) begin
			emit_req = 1'b1;
		end
	end

	assign flush_ok  = !out_v_q || pt_ready;
	assign emit_ok   = !hold_v_q || flush_ok;
	assign emit_fire = emit_req && emit_ok;
	// output register takes a new beat: a displaced held point or the final one
	assign load_out  = (emit_fire && hold_v_q) || (state_q == ST_FLUSH && hold_v_q && flush_ok);

	assign wr_en   = state_q == ST_TEST && split && lev_q != LW'(1);
	assign wr_addr = sp_q[AIW-1:0];
	assign rd_en   = state_q == ST_POP && sp_q != '0;
	assign rd_addr = AIW'(sp_q - SPW'(1));

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_full[64:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= 32'd65536;
			tol_q   <= 32'd65536;
			lp_q    <= 16'd7;
			depth_q <= 3'd6;
			negy_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_COORD_SCALE:    scale_q <= cfg_data;
				CFG_FLAT_TOLERANCE: tol_q   <= cfg_data;
				CFG_LINE_PRECISION: lp_q    <= cfg_data[15:0];
				CFG_MAX_DEPTH:      depth_q <= cfg_data[2:0];
				CFG_NEGATE_Y:       negy_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
			sp_q     <= '0;
		end else begin
			if (load_out) out_v_q <= 1'b1;
			else if (pt_ready) out_v_q <= 1'b0;
			if (emit_fire) begin
				if (hold_v_q)
					out_q <= '{point_x: hold_x_q, point_y: hold_y_q, last_point: 1'b0};
				hold_x_q <= emit_x;
				hold_y_q <= emit_y;
				hold_v_q <= 1'b1;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (seg_valid) begin
						seg_q   <= seg;
						state_q <= ST_START;
					end
				end
				ST_START: begin
					dk_q      <= 2'd0;
					dir_end_q <= 1'b0;
					state_q   <= seg_q.path_start ? ST_DIR : ST_LTEST;
				end
				ST_DIR: begin
					if (dk_q == 2'd1) px_q <= prod_s1;
					if (dk_q != 2'd2) dk_q <= dk_q + 2'd1;
					else if (emit_ok) state_q <= dir_end_q ? ST_FLUSH : ST_LTEST;
				end
				ST_LTEST: begin
					dk_q      <= 2'd0;
					dir_end_q <= 1'b1;
					cv_q      <= 4'd0;
					state_q   <= line_ok ? ST_DIR : ST_CONV;
				end
				ST_CONV: begin
					if (cv_q != 4'd0) cur_q[cv_q[2:0] - 3'd1] <= to_work(prod_s1);
					if (cv_q == 4'd8) begin
						lev_q   <= lev_init;
						sp_q    <= '0;
						state_q <= ST_DIFF;
					end else begin
						cv_q <= cv_q + 4'd1;
					end
				end
				ST_DIFF: begin
					dx_q    <= DW'(cur_q[6]) - DW'(cur_q[0]);
					dy_q    <= DW'(cur_q[7]) - DW'(cur_q[1]);
					d2x_q   <= DW'(cur_q[2]) - DW'(cur_q[6]);
					d2y_q   <= DW'(cur_q[3]) - DW'(cur_q[7]);
					d3x_q   <= DW'(cur_q[4]) - DW'(cur_q[6]);
					d3y_q   <= DW'(cur_q[5]) - DW'(cur_q[7]);
					op_q    <= OP_C2A;
					state_q <= ST_OPSET;
				end
				ST_OPSET: begin
					ma_q    <= op_a;
					mb_q    <= op_b;
					msg_q   <= op_sg;
					mp_q    <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (mb_q == '0) begin
						state_q <= ST_ACC;
					end else begin
						if (mb_q[0]) mp_q <= mp_q + ma_q;
						ma_q <= ma_q << 1;
						mb_q <= mb_q >> 1;
					end
				end
				ST_ACC: begin
					case (op_q) inside
						OP_C2A, OP_C3A: cr_q <= sprod;
						OP_C2B: d23_q <= maga(cdiff);
						OP_C3B: d23_q <= d23_q + maga(cdiff);
						OP_LHS: lhs_q <= mp_q;
						OP_DXX: nsum_q <= mp_q[AW-1:0];
						OP_DYY: nsum_q <= nsum_q + mp_q[AW-1:0];
						default: n_q <= mp_q << 16;
					endcase
					if (op_q == OP_TOL) state_q <= ST_TEST;
					else begin
						op_q    <= op_q + 3'd1;
						state_q <= ST_OPSET;
					end
				end
				ST_TEST: begin
					if (!split) begin
						if (emit_ok) state_q <= ST_POP;
					end else if (lev_q == LW'(1)) begin
						state_q <= ST_POP;
					end else begin
						// right half waits on the stack, left half goes on at once
						for (int i = 0; i < 8; i++) cur_q[i] <= lft[i];
						lev_q   <= lev_q - LW'(1);
						sp_q    <= sp_q + SPW'(1);
						state_q <= ST_DIFF;
					end
				end
				ST_POP: begin
					if (sp_q == '0) state_q <= ST_FLUSH;
					else begin
						sp_q    <= sp_q - SPW'(1);
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					for (int i = 0; i < 8; i++) cur_q[i] <= rd_q[LW + i * W +: W];
					lev_q   <= rd_q[LW-1:0];
					state_q <= ST_DIFF;
				end
				ST_FLUSH: begin
					if (!hold_v_q) state_q <= ST_IDLE;
					else if (flush_ok) begin
						out_q    <= '{point_x: hold_x_q, point_y: hold_y_q, last_point: 1'b1};
						hold_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign seg_ready = state_q == ST_IDLE;
	assign pt_valid  = out_v_q;
	assign pt        = out_q;

	a_idle_no_held: assert property (@(posedge clk) disable iff (!arst_n)
		seg_ready |-> !hold_v_q)
		else $error("held point left over while idle");

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(SD))
		else $error("stack pointer beyond depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> sp_q < SPW'(SD))
		else $error("push onto full stack");

	a_inner_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire && hold_v_q |=> pt_valid && !pt.last_point)
		else $error("displaced point marked last");

endmodule

/* dv/tb_cubic_bezier_flattener.sv */
// Self-checking testbench for the cubic Bezier flattener: random segments, configs and stalls.
module tb_cubic_bezier_flattener
	import cbf_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH_CAP   = 6;
	localparam int STACK_SLOTS = DEPTH_CAP + 1;
	localparam int POINT_CAP   = 1 + (1 << (DEPTH_CAP - 1));
	localparam int DRAIN_WAIT  = 30000;
	localparam longint CYCLE_LIMIT = 40000000;

	typedef logic signed [255:0] wide_t;

	class point_scoreboard;
		bit [31:0] scale = 32'd65536;
		bit [31:0] tol   = 32'd65536;
		bit [15:0] prec  = 16'd7;
		bit [2:0]  depth = 3'd6;
		bit        flip_y = 1'b0;
		pt_t       pending_pts[$];
		pt_t       seg_pts[$];
		int        errors = 0;

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
			case (idx)
				CFG_COORD_SCALE:    scale = val;
				CFG_FLAT_TOLERANCE: tol = val;
				CFG_LINE_PRECISION: prec = val[15:0];
				CFG_MAX_DEPTH:      depth = val[2:0];
				CFG_NEGATE_Y:       flip_y = val[0];
				default: ;
			endcase
		endfunction

		function logic signed [31:0] clamp32(bit neg, logic [65:0] r);
			if (neg) begin
				if (r > 66'h80000000) r = 66'h80000000;
				return -r[31:0];
			end
			if (r > 66'h7FFFFFFF) r = 66'h7FFFFFFF;
			return r[31:0];
		endfunction

		function void emit(bit nx, logic [63:0] mx, bit ny, logic [63:0] my, int frac);
			pt_t p;
			logic [65:0] half;
			if (seg_pts.size() >= POINT_CAP) return;
			half = 66'd1 << (frac - 1);
			p.point_x = clamp32(nx, ({2'b0, mx} + half) >> frac);
			p.point_y = clamp32(flip_y ? !ny : ny, ({2'b0, my} + half) >> frac);
			p.last_point = 1'b0;
			seg_pts = {seg_pts, p};
		endfunction

		function longint times_scale(longint c);
			longint sc;
			sc = scale;
			return c * sc;
		endfunction

		function void emit_direct(longint x, longint y);
			longint px, py;
			px = times_scale(x);
			py = times_scale(y);
			emit(px < 0, px < 0 ? -px : px, py < 0, py < 0 ? -py : py, 32);
		endfunction

		// Q.16 working value, saturated to 48 bits signed
		function longint to_q16(longint c);
			longint p;
			logic [63:0] m, r;
			p = times_scale(c);
			m = p < 0 ? -p : p;
			r = (m + 64'd32768) >> 16;
			if (p < 0) begin
				if (r > (64'd1 << 47)) r = 64'd1 << 47;
				return -longint'(r);
			end
			if (r > (64'd1 << 47) - 1) r = (64'd1 << 47) - 1;
			return longint'(r);
		endfunction

		function bit not_flat(longint q[8]);
			wide_t dx, dy, ax, ay, bx, by, c2, c3, lhs, rhs;
			dx = wide_t'(q[6] - q[0]);
			dy = wide_t'(q[7] - q[1]);
			ax = wide_t'(q[2] - q[6]);
			ay = wide_t'(q[3] - q[7]);
			bx = wide_t'(q[4] - q[6]);
			by = wide_t'(q[5] - q[7]);
			c2 = ax * dy - ay * dx;
			c3 = bx * dy - by * dx;
			if (c2 < 0) c2 = -c2;
			if (c3 < 0) c3 = -c3;
			lhs = (c2 + c3) * (c2 + c3);
			rhs = (dx * dx + dy * dy) * wide_t'({224'd0, tol}) * wide_t'(65536);
			return lhs >= rhs;
		endfunction

		function void note_segment(seg_t s);
			longint v[8];
			longint thr, q[8], l[8], r[8], a12, a23, a34, a123, a234, a1234;
			longint stk[STACK_SLOTS][8];
			int lvl[STACK_SLOTS];
			int top, lev;
			bit straight;
			v[0] = s.start_x; v[1] = s.start_y; v[2] = s.ctrl1_x; v[3] = s.ctrl1_y;
			v[4] = s.ctrl2_x; v[5] = s.ctrl2_y; v[6] = s.end_x;   v[7] = s.end_y;
			seg_pts.delete();
			thr = 3 * longint'(prec);
			if (s.path_start) emit_direct(v[0], v[1]);
			straight = (3*v[2] - 2*v[0] - v[6] < thr) && (-(3*v[2] - 2*v[0] - v[6]) < thr) &&
				(3*v[4] - 2*v[6] - v[0] < thr) && (-(3*v[4] - 2*v[6] - v[0]) < thr) &&
				(3*v[3] - 2*v[1] - v[7] < thr) && (-(3*v[3] - 2*v[1] - v[7]) < thr) &&
				(3*v[5] - 2*v[7] - v[1] < thr) && (-(3*v[5] - 2*v[7] - v[1]) < thr);
			if (straight) begin
				emit_direct(v[6], v[7]);
			end else begin
				lev = depth;
				if (lev < 1) lev = 1;
				if (lev > DEPTH_CAP) lev = DEPTH_CAP;
				for (int i = 0; i < 8; i++) stk[0][i] = to_q16(v[i]);
				lvl[0] = lev;
				top = 1;
				while (top > 0) begin
					top--;
					q = stk[top];
					lev = lvl[top];
					if (!not_flat(q)) begin
						emit(q[6] < 0, q[6] < 0 ? -q[6] : q[6], q[7] < 0, q[7] < 0 ? -q[7] : q[7], 16);
						continue;
					end
					lev--;
					if (lev == 0) continue;
					for (int i = 0; i < 2; i++) begin
						a12 = (q[i] + q[2+i]) >>> 1;
						a23 = (q[2+i] + q[4+i]) >>> 1;
						a34 = (q[4+i] + q[6+i]) >>> 1;
						a123 = (a12 + a23) >>> 1;
						a234 = (a23 + a34) >>> 1;
						a1234 = (a123 + a234) >>> 1;
						l[i] = q[i];   l[2+i] = a12;  l[4+i] = a123; l[6+i] = a1234;
						r[i] = a1234; r[2+i] = a234; r[4+i] = a34;  r[6+i] = q[6+i];
					end
					if (top < STACK_SLOTS) begin stk[top] = r; lvl[top] = lev; top++; end
					if (top < STACK_SLOTS) begin stk[top] = l; lvl[top] = lev; top++; end
				end
			end
			if (seg_pts.size() > 0) seg_pts[seg_pts.size()-1].last_point = 1'b1;
			pending_pts = {pending_pts, seg_pts};
		endfunction

		function void check_point(pt_t got);
			pt_t want;
			if (pending_pts.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected point: x=%0d y=%0d last=%0b",
						got.point_x, got.point_y, got.last_point);
				return;
			end
			want = pending_pts.pop_front();
			if (got.point_x !== want.point_x || got.point_y !== want.point_y ||
					got.last_point !== want.last_point) begin
				errors++;
				if (errors <= 10)
					$display("point mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
						want.point_x, want.point_y, want.last_point,
						got.point_x, got.point_y, got.last_point);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic seg_valid, seg_ready, pt_valid, pt_ready, cfg_we;
	seg_t seg;
	pt_t pt;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	point_scoreboard sb = new();
	bit calm_out = 0;
	longint cycles = 0;

	cubic_bezier_flattener dut (
		.clk(clk), .arst_n(arst_n),
		.seg_valid(seg_valid), .seg_ready(seg_ready), .seg(seg),
		.pt_valid(pt_valid), .pt_ready(pt_ready), .pt(pt),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial clk = 0;
	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && seg_valid && seg_ready) sb.note_segment(seg);
		if (arst_n && pt_valid && pt_ready) sb.check_point(pt);
	end

	// point receiver with random stalls
	initial begin
		int stall;
		pt_ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = calm_out ? 0 : $urandom_range(0, 9);
			pt_ready = 0;
			repeat (stall) @(negedge clk);
			pt_ready = 1;
			do @(posedge clk); while (!pt_valid);
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = val;
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_we = 0;
	endtask

	// called at a falling edge, returns at a falling edge
	task automatic send_segment(seg_t s, bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			seg_valid = 0;
			repeat (gap) @(negedge clk);
		end
		seg = s;
		seg_valid = 1;
		do @(posedge clk); while (!seg_ready);
		@(negedge clk);
		seg_valid = 0;
	endtask

	task automatic wait_drained();
		while (sb.pending_pts.size() != 0) @(negedge clk);
	endtask

	function automatic int signed coord_small(int span);
		return $signed($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic seg_t make_seg(int shape);
		seg_t s;
		int signed k;
		s.path_start = $urandom_range(0, 1);
		case (shape)
			0: begin
				s.start_x = coord_small(200 << 16); s.start_y = coord_small(200 << 16);
				s.ctrl1_x = coord_small(200 << 16); s.ctrl1_y = coord_small(200 << 16);
				s.ctrl2_x = coord_small(200 << 16); s.ctrl2_y = coord_small(200 << 16);
				s.end_x = coord_small(200 << 16);   s.end_y = coord_small(200 << 16);
			end
			1: begin
				s.start_x = coord_small(1 << 24); s.start_y = coord_small(1 << 24);
				k = coord_small(1 << 22);
				s.end_x = s.start_x + 3 * k;
				s.ctrl1_x = s.start_x + k + coord_small(8);
				s.ctrl2_x = s.start_x + 2 * k + coord_small(8);
				k = coord_small(1 << 22);
				s.end_y = s.start_y + 3 * k;
				s.ctrl1_y = s.start_y + k + coord_small(8);
				s.ctrl2_y = s.start_y + 2 * k + coord_small(8);
			end
			2: begin
				s.start_x = $urandom; s.start_y = $urandom;
				s.ctrl1_x = $urandom; s.ctrl1_y = $urandom;
				s.ctrl2_x = $urandom; s.ctrl2_y = $urandom;
				s.end_x = $urandom;   s.end_y = $urandom;
			end
			default: begin
				s = make_seg(0);
				s.end_x = s.start_x;
				s.end_y = s.start_y;
			end
		endcase
		return s;
	endfunction

	task automatic run_random(int count);
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (i == count / 2) wait_drained();
			send_segment(make_seg(pick < 55 ? 0 : pick < 75 ? 1 : pick < 95 ? 2 : 3),
				$urandom_range(0, 3) == 0);
		end
	endtask

	function automatic seg_t seg_of(int sx, int sy, int ax, int ay, int bx, int by,
			int ex, int ey, bit ps);
		seg_t s;
		s.start_x = sx; s.start_y = sy; s.ctrl1_x = ax; s.ctrl1_y = ay;
		s.ctrl2_x = bx; s.ctrl2_y = by; s.end_x = ex; s.end_y = ey; s.path_start = ps;
		return s;
	endfunction

	initial begin
		int mx, mn;
		mx = 32'h7FFFFFFF;
		mn = 32'h80000000;
		arst_n = 0;
		seg_valid = 0;
		seg = '0;
		cfg_we = 0;
		cfg_index = CFG_COORD_SCALE;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// defaults: straight lines, curves, degenerate chord, extremes
		send_segment(seg_of(0, 0, 1 << 16, 1 << 16, 2 << 16, 2 << 16, 3 << 16, 3 << 16, 1), 0);
		send_segment(seg_of(0, 0, 10 << 16, 0, 10 << 16, 10 << 16, 0, 10 << 16, 1), 0);
		send_segment(seg_of(0, 0, 10 << 16, 0, 10 << 16, 10 << 16, 0, 10 << 16, 0), 0);
		send_segment(seg_of(5 << 16, 5 << 16, 9 << 16, 1 << 16, 1 << 16, 9 << 16,
			5 << 16, 5 << 16, 1), 0);
		send_segment(seg_of(mx, mx, mx, mx, mx, mx, mx, mx, 1), 0);
		send_segment(seg_of(mn, mn, mn, mn, mn, mn, mn, mn, 1), 1);
		send_segment(seg_of(mn, mx, mx, mn, mn, mx, mx, mn, 1), 0);
		send_segment(seg_of(mn, mn, mx, mn, mn, mx, mx, mx, 0), 0);
		send_segment(seg_of(32768, -32768, 0, 0, 0, 0, -32768, 32768, 1), 0);
		send_segment(seg_of(-1, -1, 100 << 16, -3 << 16, -50 << 16, 77 << 16,
			30 << 16, 31 << 16, 1), 1);
		send_segment(seg_of(0, 0, 6, 0, 14, 0, 21, 0, 1), 0);
		send_segment(seg_of(0, 0, 7, 7, 14, 14, 21, 21, 1), 0);
		run_random(24);
		wait_drained();
		repeat (DRAIN_WAIT) @(negedge clk);

		// extremes: huge scale, zero tolerance, widest precision, shallow depth
		write_reg(CFG_COORD_SCALE, 32'hFFFFFFFF);
		write_reg(CFG_FLAT_TOLERANCE, 32'd0);
		write_reg(CFG_LINE_PRECISION, 32'hFFFF);
		write_reg(CFG_MAX_DEPTH, 32'd1);
		write_reg(CFG_NEGATE_Y, 32'd1);
		send_segment(seg_of(mx, mn, mx, mn, mx, mn, mx, mn, 1), 0);
		send_segment(seg_of(mn, mx, 0, 0, 0, 0, mx, mn, 1), 0);
		calm_out = 1;
		run_random(24);
		calm_out = 0;
		wait_drained();
		repeat (DRAIN_WAIT) @(negedge clk);

		write_reg(CFG_COORD_SCALE, 32'd0);
		write_reg(CFG_FLAT_TOLERANCE, 32'hFFFFFFFF);
		write_reg(CFG_LINE_PRECISION, 32'd0);
		write_reg(CFG_MAX_DEPTH, 32'd0);
		write_reg(CFG_NEGATE_Y, 32'd0);
		run_random(12);
		wait_drained();
		repeat (DRAIN_WAIT) @(negedge clk);

		write_reg(CFG_COORD_SCALE, 32'd40000);
		write_reg(CFG_FLAT_TOLERANCE, 32'd300);
		write_reg(CFG_LINE_PRECISION, 32'd3);
		write_reg(CFG_MAX_DEPTH, 32'd7);
		write_reg(CFG_NEGATE_Y, 32'd1);
		run_random(24);
		wait_drained();
		repeat (DRAIN_WAIT) @(negedge clk);

		write_reg(CFG_COORD_SCALE, 32'd65536 + $urandom_range(0, 1 << 20));
		write_reg(CFG_FLAT_TOLERANCE, $urandom_range(1, 1 << 18));
		write_reg(CFG_LINE_PRECISION, $urandom_range(0, 64));
		write_reg(CFG_MAX_DEPTH, $urandom_range(2, 5));
		write_reg(CFG_NEGATE_Y, $urandom_range(0, 1));
		run_random(24);

		wait_drained();
		repeat (DRAIN_WAIT) @(negedge clk);
		if (sb.errors == 0 && sb.pending_pts.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
